FILE: hdl/rtms_pkg.sv
// Shared types, constants and codes for the route table mark-and-sweep core.
package rtms_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ADDR_W      = 32;
  localparam int METRIC_W    = 16;
  localparam int ROUTE_W     = 2 * ADDR_W + METRIC_W;

  typedef logic [IDX_W-1:0] idx_t;

  // The destination sits in the lowest bits, as on the stream ports.
  typedef struct packed {
    logic [METRIC_W-1:0] metric;
    logic [ADDR_W-1:0]   gateway;
    logic [ADDR_W-1:0]   dst;
  } route_t;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_OFFER = 2'd1,
    CMD_SWEEP = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_ACK     = 3'd0,
    KIND_MATCHED = 3'd1,
    KIND_ADDED   = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_DELETE  = 3'd4,
    KIND_DONE    = 3'd5
  } kind_t;

  typedef struct packed {
    logic  load_item;
    logic  clear_seen;
    logic  set_seen;
    logic  write_entry;
    logic  free_entry;
    logic  out_load;
    logic  out_del;
    kind_t out_kind;
    idx_t  idx;
    idx_t  widx;
  } ctl_t;

  typedef struct packed {
    logic hit;
    logic victim;
    logic empty;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/rtms_datapath.sv
// Route table storage, valid and seen marks, match compare and result register.
module rtms_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rtms_pkg::ctl_t              ctl,
  output rtms_pkg::sts_t              sts,
  input  logic [rtms_pkg::ROUTE_W-1:0] in_route,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [rtms_pkg::ROUTE_W-1:0] out_route,
  output logic [2:0]                  out_kind,
  output logic                        out_last
);

  rtms_pkg::route_t entry_r [rtms_pkg::TABLE_DEPTH];
  rtms_pkg::route_t offer_r;
  rtms_pkg::route_t rd_route;
  rtms_pkg::route_t out_route_r;
  logic [rtms_pkg::TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [rtms_pkg::TABLE_DEPTH-1:0] seen_r, seen_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [2:0] out_kind_r;
  logic out_last_r;

  assign rd_route = entry_r[ctl.idx];

  assign sts.hit      = valid_r[ctl.idx] && (rd_route == offer_r);
  assign sts.victim   = valid_r[ctl.idx] && !seen_r[ctl.idx];
  assign sts.empty    = !valid_r[ctl.idx];
  assign sts.out_free = !out_valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    seen_nxt  = seen_r;
    if (ctl.clear_seen) begin
      seen_nxt = '0;
    end
    if (ctl.set_seen) begin
      seen_nxt[ctl.idx] = 1'b1;
    end
    if (ctl.write_entry) begin
      valid_nxt[ctl.widx] = 1'b1;
      seen_nxt[ctl.widx]  = 1'b1;
    end
    if (ctl.free_entry) begin
      valid_nxt[ctl.idx] = 1'b0;
      seen_nxt[ctl.idx]  = 1'b0;
    end
  end

  always_comb begin
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      offer_r <= rtms_pkg::route_t'(in_route);
    end
    if (ctl.write_entry) begin
      entry_r[ctl.widx] <= offer_r;
    end
    if (ctl.out_load) begin
      out_route_r <= ctl.out_del ? rd_route : '0;
      out_kind_r  <= ctl.out_kind;
      out_last_r  <= !ctl.out_del;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_route  = out_route_r;
  assign out_kind   = out_kind_r;
  assign out_last   = out_last_r;

endmodule

FILE: hdl/rtms_ctrl.sv
// Controller state machine that sequences the offer search and the sweep scan.
module rtms_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [1:0]     in_cmd,
  input  rtms_pkg::sts_t sts,
  output rtms_pkg::ctl_t ctl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OFFER,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  rtms_pkg::idx_t      idx_r, idx_nxt;
  rtms_pkg::idx_t      free_r, free_nxt;
  logic                found_r, found_nxt;
  rtms_pkg::kind_t     kind_r, kind_nxt;
  logic                at_end;

  assign at_end    = (idx_r == rtms_pkg::IDX_W'(rtms_pkg::TABLE_DEPTH - 1));
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    free_nxt  = free_r;
    found_nxt = found_r;
    kind_nxt  = kind_r;
    ctl          = '0;
    ctl.idx      = idx_r;
    ctl.widx     = found_r ? free_r : idx_r;
    ctl.out_kind = kind_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (rtms_pkg::cmd_t'(in_cmd))
            rtms_pkg::CMD_BEGIN: begin
              ctl.clear_seen = 1'b1;
              kind_nxt       = rtms_pkg::KIND_ACK;
              state_nxt      = ST_EMIT;
            end
            rtms_pkg::CMD_OFFER: begin
              ctl.load_item = 1'b1;
              idx_nxt       = '0;
              found_nxt     = 1'b0;
              state_nxt     = ST_OFFER;
            end
            rtms_pkg::CMD_SWEEP: begin
              idx_nxt   = '0;
              state_nxt = ST_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_OFFER: begin
        if (sts.hit) begin
          ctl.set_seen = 1'b1;
          kind_nxt     = rtms_pkg::KIND_MATCHED;
          state_nxt    = ST_EMIT;
        end else begin
          if (sts.empty && !found_r) begin
            found_nxt = 1'b1;
            free_nxt  = idx_r;
          end
          if (at_end) begin
            if (found_r || sts.empty) begin
              ctl.write_entry = 1'b1;
              kind_nxt        = rtms_pkg::KIND_ADDED;
            end else begin
              kind_nxt = rtms_pkg::KIND_FULL;
            end
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt = idx_r + rtms_pkg::IDX_W'(1);
          end
        end
      end
      ST_SWEEP: begin
        if (sts.victim && sts.out_free) begin
          ctl.out_load   = 1'b1;
          ctl.out_del    = 1'b1;
          ctl.out_kind   = rtms_pkg::KIND_DELETE;
          ctl.free_entry = 1'b1;
        end
        if (!sts.victim || sts.out_free) begin
          if (at_end) begin
            kind_nxt  = rtms_pkg::KIND_DONE;
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt = idx_r + rtms_pkg::IDX_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      free_r  <= '0;
      found_r <= 1'b0;
      kind_r  <= rtms_pkg::KIND_ACK;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      free_r  <= free_nxt;
      found_r <= found_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

FILE: hdl/route_table_mark_sweep_core.sv
// Top level of the route table mark-and-sweep core.
// The core holds TABLE_DEPTH routes and takes one command item at a time. The table has a
// single read port, so a scan visits one entry per cycle unless a sweep holds. A begin
// item returns its acknowledge. An offer item that matches an entry returns as soon as
// the search reaches it, because the search stops at the match. An offer item that adds
// the route or finds the table full returns once the search has visited every entry. A
// sweep item visits every entry and holds while a delete result waits for the downstream
// side. Every result also waits while the output register still holds an item that the
// downstream side has not taken. The next item is accepted as soon as the last result of
// the previous one sits in the output register. Code 3 is consumed without any result.
module route_table_mark_sweep_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // dst [31:0], gateway [63:32], metric [79:64]
  input  logic [rtms_pkg::ROUTE_W-1:0] in_tdata,
  // cmd [1:0]
  input  logic [1:0]                   in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // out_dst [31:0], out_gateway [63:32], out_metric [79:64]
  output logic [rtms_pkg::ROUTE_W-1:0] out_tdata,
  // kind [2:0]
  output logic [2:0]                   out_tuser,
  output logic                         out_tlast
);

  rtms_pkg::ctl_t ctl;
  rtms_pkg::sts_t sts;

  rtms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .sts       (sts),
    .ctl       (ctl)
  );

  rtms_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_route   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_route  (out_tdata),
    .out_kind   (out_tuser),
    .out_last   (out_tlast)
  );

endmodule
